>>> rtl/sclx_pkg.sv
// Shared types and constants of the command line lexer.
package sclx_pkg;

  localparam int MaxRes    = 3;
  localparam int ResIdxW   = $clog2(MaxRes);
  localparam int QDepth    = 4;
  localparam int QAddrW    = $clog2(QDepth);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] CntMax  = 8'hFF;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_LT     = 3'd3,
    MODE_GT     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_END  = 2'd1,
    KIND_LINE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CLS_WORD    = 3'd0,
    CLS_PIPE    = 3'd1,
    CLS_IN      = 3'd2,
    CLS_OUT     = 3'd3,
    CLS_HEREDOC = 3'd4,
    CLS_APPEND  = 3'd5
  } tok_class_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    tok_class_t cls;
    logic [7:0] index;
    logic       line_done;
  } result_t;

  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [ResIdxW-1:0]   count;
  } bundle_t;

endpackage

>>> rtl/sclx_front.sv
// Front end: lexer state, byte classification and result bundle build.
module sclx_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_eol,
  input  logic            q_full,
  output logic            q_push,
  output sclx_pkg::bundle_t q_data
);
  import sclx_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic       quote_r, quote_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       fire;

  logic       is_sp, is_pipe, is_lt, is_gt, is_q, is_dq, eol;
  logic       ic_pipe, ic_text, ic_quote;
  mode_t      ic_mode;
  logic [2:0] slot_v;
  result_t    slot_res [MaxRes];
  bundle_t    bundle;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  assign is_sp   = (in_byte == ChSpace) || (in_byte >= ChTab && in_byte <= ChCr);
  assign is_pipe = (in_byte == ChPipe);
  assign is_lt   = (in_byte == ChLt);
  assign is_gt   = (in_byte == ChGt);
  assign is_dq   = (in_byte == ChDq);
  assign is_q    = is_dq || (in_byte == ChSq);
  assign eol     = in_eol || (in_byte == ChNul);

  // outcome of a byte seen outside any token
  always_comb begin
    ic_pipe  = 1'b0;
    ic_text  = 1'b0;
    ic_quote = quote_r;
    priority if (is_sp) begin
      ic_mode = MODE_IDLE;
    end else if (is_pipe) begin
      ic_mode = MODE_IDLE;
      ic_pipe = 1'b1;
    end else if (is_lt) begin
      ic_mode = MODE_LT;
    end else if (is_gt) begin
      ic_mode = MODE_GT;
    end else if (is_q) begin
      ic_mode  = MODE_QUOTED;
      ic_quote = is_dq;
      ic_text  = !is_dq;
    end else begin
      ic_mode = MODE_WORD;
      ic_text = 1'b1;
    end
  end

  // slot 0: first token end, slot 1: pipe or text, slot 2: line end
  always_comb begin
    mode_t      m;
    logic       use_ic;
    logic [7:0] cnt;
    logic [ResIdxW-1:0] n;
    result_t    blank;

    blank     = '{kind: KIND_TEXT, data: 8'd0, cls: CLS_WORD, index: 8'd0, line_done: 1'b0};
    slot_v    = '0;
    slot_res[0] = blank;
    slot_res[1] = blank;
    slot_res[2] = blank;
    slot_res[0].kind = KIND_END;
    m         = mode_r;
    quote_nxt = quote_r;
    use_ic    = 1'b0;

    if (in_byte != ChNul) begin
      unique case (mode_r)
        MODE_WORD: begin
          if (is_sp || is_pipe || is_lt || is_gt) begin
            slot_v[0]       = 1'b1;
            slot_res[0].cls = CLS_WORD;
            use_ic          = 1'b1;
          end else if (is_q) begin
            m         = MODE_QUOTED;
            quote_nxt = is_dq;
            slot_v[1] = !is_dq;
          end else begin
            slot_v[1] = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (in_byte == (quote_r ? ChDq : ChSq)) begin
            m = MODE_WORD;
          end
          slot_v[1] = !is_dq;
        end
        MODE_LT, MODE_GT: begin
          slot_v[0] = 1'b1;
          if ((mode_r == MODE_LT && is_lt) || (mode_r == MODE_GT && is_gt)) begin
            slot_res[0].cls = (mode_r == MODE_LT) ? CLS_HEREDOC : CLS_APPEND;
            m               = MODE_IDLE;
          end else begin
            slot_res[0].cls = (mode_r == MODE_LT) ? CLS_IN : CLS_OUT;
            use_ic          = 1'b1;
          end
        end
        default: begin
          use_ic = 1'b1;
        end
      endcase
      if (use_ic) begin
        m         = ic_mode;
        quote_nxt = ic_quote;
        slot_v[1] = ic_pipe || ic_text;
        if (ic_pipe) begin
          slot_res[1].kind = KIND_END;
          slot_res[1].cls  = CLS_PIPE;
        end
      end
      slot_res[1].data = (slot_res[1].kind == KIND_TEXT) ? in_byte : 8'd0;
    end

    if (eol) begin
      unique case (m)
        MODE_LT: begin
          slot_v[2]        = 1'b1;
          slot_res[2].kind = KIND_END;
          slot_res[2].cls  = CLS_IN;
        end
        MODE_GT: begin
          slot_v[2]        = 1'b1;
          slot_res[2].kind = KIND_END;
          slot_res[2].cls  = CLS_OUT;
        end
        MODE_WORD, MODE_QUOTED: begin
          slot_v[2]        = 1'b1;
          slot_res[2].kind = KIND_END;
          slot_res[2].cls  = CLS_WORD;
        end
        default: begin
          slot_v[2]        = !slot_v[0] && !slot_v[1];
          slot_res[2].kind = KIND_LINE;
        end
      endcase
    end

    // pack valid slots in order and number the tokens
    bundle.res[0] = blank;
    bundle.res[1] = blank;
    bundle.res[2] = blank;
    cnt = cnt_r;
    n   = '0;
    for (int i = 0; i < MaxRes; i++) begin
      if (slot_v[i]) begin
        bundle.res[n]       = slot_res[i];
        bundle.res[n].index = cnt;
        if (slot_res[i].kind == KIND_END && cnt != CntMax) begin
          cnt = cnt + 8'd1;
        end
        n = n + ResIdxW'(1);
      end
    end
    bundle.count = n;
    if (eol && n != '0) begin
      bundle.res[n - ResIdxW'(1)].line_done = 1'b1;
    end

    if (eol) begin
      mode_nxt  = MODE_IDLE;
      quote_nxt = 1'b0;
      cnt_nxt   = 8'd0;
    end else begin
      mode_nxt  = m;
      cnt_nxt   = cnt;
    end
  end

  assign q_push = fire && (bundle.count != '0);
  assign q_data = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      quote_r <= 1'b0;
      cnt_r   <= 8'd0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/sclx_queue.sv
// Bundle queue between the front end and the back end.
module sclx_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sclx_pkg::bundle_t push_data,
  input  logic              pop,
  output sclx_pkg::bundle_t head,
  output logic              empty,
  output logic              full
);
  import sclx_pkg::*;

  bundle_t           mem_r [QDepth];
  logic [QAddrW-1:0] wr_r, wr_nxt;
  logic [QAddrW-1:0] rd_r, rd_nxt;
  logic [QAddrW:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (QAddrW+1)'(QDepth));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + QAddrW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QAddrW'(1) : rd_r;
    cnt_nxt = cnt_r + (QAddrW+1)'(do_push) - (QAddrW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/sclx_back.sv
// Back end: walks each bundle and drives the registered result channel.
module sclx_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sclx_pkg::bundle_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output sclx_pkg::result_t out_res,
  output logic              out_last
);
  import sclx_pkg::*;

  logic [ResIdxW-1:0] sub_r, sub_nxt;
  logic               valid_r, valid_nxt;
  result_t            res_r;
  logic               last_r;
  logic               load, at_last;

  assign load    = !empty && (!valid_r || out_ready);
  assign at_last = (sub_r == head.count - ResIdxW'(1));
  assign pop     = load && at_last;

  always_comb begin
    sub_nxt = sub_r;
    if (load) begin
      sub_nxt = at_last ? '0 : sub_r + ResIdxW'(1);
    end
    valid_nxt = load || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= head.res[sub_r];
      last_r <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      sub_r   <= sub_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

>>> rtl/shell_command_line_lexer_unit.sv
// Top level of the command line lexer.
//
//   channel | direction | beat contents
//   in      | input     | in_byte, in_end_of_line
//   out     | output    | out_kind, out_byte, out_token_class, out_token_index,
//           |           | out_line_done, out_last_of_run
//
// The front end takes one byte per cycle while the queue is not full and writes its zero
// to three results as one bundle into a four-entry queue; bytes with no result write nothing.
// The back end sends one result beat per cycle while out_ready is high and the queue is not
// empty; its output is registered, so a byte's results pass the queue and that register first.
// in_ready drops only while the queue is full; out_ready stalls only the back.
// Synchronous reset returns the lexer to outside any token with count zero.
module shell_command_line_lexer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_token_class,
  output logic [7:0] out_token_index,
  output logic       out_line_done,
  output logic       out_last_of_run
);
  import sclx_pkg::*;

  bundle_t q_data, q_head;
  logic    q_push, q_pop, q_empty, q_full;
  result_t res;

  sclx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_eol   (in_end_of_line),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  sclx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  sclx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last_of_run)
  );

  assign out_kind        = res.kind;
  assign out_byte        = res.data;
  assign out_token_class = res.cls;
  assign out_token_index = res.index;
  assign out_line_done   = res.line_done;

  a_line_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |-> out_last_of_run)
    else $error("line end beat is not the last of its run");

  a_line_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_LINE |-> out_line_done && out_token_class == CLS_WORD)
    else $error("bare line end beat malformed");

  a_text_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TEXT |-> !out_line_done && out_token_class == CLS_WORD)
    else $error("text beat carries line end or class");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full && in_valid)
    else $error("queue written while full");

endmodule

>>> dv/sclx_lex_checker.sv
// Checker for the command line lexer: predicts the token beats and compares them at the output.
`timescale 1ns / 1ps
module sclx_lex_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_line,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_byte,
  input  logic [2:0] out_token_class,
  input  logic [7:0] out_token_index,
  input  logic       out_line_done,
  input  logic       out_last_of_run,
  output int         err_count,
  output int         pending
);
  import sclx_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    tok_class_t cls;
    logic [7:0] index;
    logic       line_done;
    logic       last;
  } token_beat_t;

  mode_t       lex_mode = MODE_IDLE;
  logic        dq_open = 1'b0;
  logic [7:0]  tok_cnt = 8'h00;
  token_beat_t step_beats [MaxRes];
  int          step_n;
  token_beat_t token_beats_q [$];
  token_beat_t head;
  int          fail_cnt = 0;
  int          pend_cnt = 0;

  assign err_count = fail_cnt;
  assign pending   = pend_cnt;

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void add_beat(kind_t k, logic [7:0] b, tok_class_t c);
    if (step_n < MaxRes) begin
      step_beats[step_n] = '{kind: k, data: b, cls: c, index: tok_cnt,
                             line_done: 1'b0, last: 1'b0};
      step_n++;
      if (k == KIND_END && tok_cnt != CntMax) tok_cnt++;
    end
  endfunction

  function automatic void add_text(logic [7:0] c);
    if (c != ChDq) add_beat(KIND_TEXT, c, CLS_WORD);
  endfunction

  function automatic void start_quote(logic [7:0] c);
    dq_open  = (c == ChDq);
    lex_mode = MODE_QUOTED;
    add_text(c);
  endfunction

  function automatic void idle_byte(logic [7:0] c);
    if (is_blank(c)) begin
      lex_mode = MODE_IDLE;
    end else if (c == ChPipe) begin
      add_beat(KIND_END, 8'h00, CLS_PIPE);
      lex_mode = MODE_IDLE;
    end else if (c == ChLt) begin
      lex_mode = MODE_LT;
    end else if (c == ChGt) begin
      lex_mode = MODE_GT;
    end else if (c == ChSq || c == ChDq) begin
      start_quote(c);
    end else begin
      lex_mode = MODE_WORD;
      add_text(c);
    end
  endfunction

  function automatic void take_byte(logic [7:0] c);
    logic [7:0] closer;
    logic [7:0] pair;
    case (lex_mode)
      MODE_WORD: begin
        if (is_blank(c) || c == ChPipe || c == ChLt || c == ChGt) begin
          add_beat(KIND_END, 8'h00, CLS_WORD);
          idle_byte(c);
        end else if (c == ChSq || c == ChDq) begin
          start_quote(c);
        end else begin
          add_text(c);
        end
      end
      MODE_QUOTED: begin
        closer = dq_open ? ChDq : ChSq;
        if (c == closer) lex_mode = MODE_WORD;
        add_text(c);
      end
      MODE_LT, MODE_GT: begin
        pair = (lex_mode == MODE_LT) ? ChLt : ChGt;
        if (c == pair) begin
          add_beat(KIND_END, 8'h00, (lex_mode == MODE_LT) ? CLS_HEREDOC : CLS_APPEND);
          lex_mode = MODE_IDLE;
        end else begin
          add_beat(KIND_END, 8'h00, (lex_mode == MODE_LT) ? CLS_IN : CLS_OUT);
          lex_mode = MODE_IDLE;
          idle_byte(c);
        end
      end
      default: idle_byte(c);
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic eol);
    logic line_end;
    line_end = eol || b == ChNul;
    step_n = 0;
    if (b != ChNul) take_byte(b);
    if (line_end) begin
      case (lex_mode)
        MODE_LT:                add_beat(KIND_END, 8'h00, CLS_IN);
        MODE_GT:                add_beat(KIND_END, 8'h00, CLS_OUT);
        MODE_WORD, MODE_QUOTED: add_beat(KIND_END, 8'h00, CLS_WORD);
        default: ;
      endcase
      if (!(step_n > 0 && step_beats[step_n-1].kind == KIND_END))
        add_beat(KIND_LINE, 8'h00, CLS_WORD);
      step_beats[step_n-1].line_done = 1'b1;
      lex_mode = MODE_IDLE;
      dq_open  = 1'b0;
      tok_cnt  = 8'h00;
    end
    if (step_n > 0) step_beats[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_beats_q.push_back(step_beats[i]);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_mode = MODE_IDLE;
      dq_open  = 1'b0;
      tok_cnt  = 8'h00;
    end else begin
      if (out_valid && out_ready) begin
        if (token_beats_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual kind %0d byte %0d",
                   $time, out_kind, out_byte);
          fail_cnt++;
        end else begin
          head = token_beats_q.pop_front();
          check_field("kind", head.kind, out_kind);
          check_field("out_byte", head.data, out_byte);
          check_field("token_class", head.cls, out_token_class);
          check_field("token_index", head.index, out_token_index);
          check_field("line_done", head.line_done, out_line_done);
          check_field("last_of_run", head.last, out_last_of_run);
        end
      end
      if (in_valid && in_ready) predict_tokens(in_byte, in_end_of_line);
    end
    pend_cnt <= token_beats_q.size();
  end

endmodule

>>> dv/tb_shell_command_line_lexer_unit.sv
// Testbench top for the command line lexer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_shell_command_line_lexer_unit;
  import sclx_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_line = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] out_token_class;
  logic [7:0] out_token_index;
  logic       out_line_done;
  logic       out_last_of_run;

  int         err_count;
  int         pending;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         sent_cnt = 0;
  logic       hold_req = 1'b0;
  logic       hold_taken = 1'b0;
  int         hold_left = 0;
  logic [7:0] line_q [$];

  shell_command_line_lexer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_token_class (out_token_class),
    .out_token_index (out_token_index),
    .out_line_done   (out_line_done),
    .out_last_of_run (out_last_of_run)
  );

  sclx_lex_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_token_class (out_token_class),
    .out_token_index (out_token_index),
    .out_line_done   (out_line_done),
    .out_last_of_run (out_last_of_run),
    .err_count       (err_count),
    .pending         (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready  <= 1'b0;
      hold_left  <= 80;
      hold_taken <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_beat(logic [7:0] b, logic eol);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_line <= eol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_beat(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic send_str(string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c <= ChSpace || c == ChPipe || c == ChLt || c == ChGt || c == ChDq || c == ChSq)
      c = 8'($urandom_range(8'h61, 8'h7A));
    return c;
  endfunction

  function automatic logic [7:0] span_char(logic [7:0] closer);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == closer) c = 8'h78;
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(1)) return ChSpace;
    return 8'($urandom_range(ChTab, ChCr));
  endfunction

  task automatic gen_line(int max_toks);
    int         n;
    int         pick;
    int         len;
    logic [7:0] q;
    line_q.delete();
    n = $urandom_range(1, max_toks);
    for (int t = 0; t < n; t++) begin
      pick = $urandom_range(0, 11);
      len  = $urandom_range(1, 6);
      case (pick)
        0, 1, 2, 3: repeat (len) line_q.push_back(word_char());
        4, 5: begin
          q = (pick == 4) ? ChSq : ChDq;
          line_q.push_back(q);
          repeat (len) line_q.push_back(span_char(q));
          if ($urandom_range(0, 9) != 0) line_q.push_back(q);
        end
        6: line_q.push_back(ChPipe);
        7, 8: begin
          q = (pick == 7) ? ChLt : ChGt;
          line_q.push_back(q);
          if ($urandom_range(1)) line_q.push_back(q);
        end
        9: begin
          if ($urandom_range(1)) line_q.push_back(word_char());
          line_q.push_back(ChDq);
          line_q.push_back(ChDq);
          if ($urandom_range(1)) line_q.push_back(word_char());
        end
        10: begin
          if ($urandom_range(0, 4) == 0) line_q.push_back(ChNul);
          else line_q.push_back(8'($urandom_range(0, 255)));
        end
        default: repeat (len) line_q.push_back(blank_char());
      endcase
      if ($urandom_range(0, 3) != 0) line_q.push_back(blank_char());
    end
  endtask

  task automatic gen_dense(int n);
    int pick;
    line_q.delete();
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 17) line_q.push_back(ChPipe);
      else if (pick == 17) line_q.push_back(ChLt);
      else if (pick == 18) line_q.push_back(ChGt);
      else line_q.push_back(8'h61);
    end
  endtask

  task automatic run_random(int items, int tx_pct, int rx_pct);
    int stop_at;
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    stop_at = sent_cnt + items;
    while (sent_cnt < stop_at) begin
      gen_line(8);
      send_line();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_str("a<<b>>c|d<e>f");
    send_str("'\"| '\"\"");
    send_beat(ChLt, 1'b0);
    send_beat(ChNul, 1'b0);
    send_beat(8'h0B, 1'b1);
    send_beat(ChDq, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b1);

    run_random(80, 18, 80);
    run_random(80, 80, 18);

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    gen_dense(40);
    send_line();
    run_random(80, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
